/* rtl/core/cnb_pkg.sv */
package cnb_pkg;

  localparam int DEF_MAX_COLS = 64;
  localparam int DEF_MAX_ROWS = 32;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 6;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int SUM_W   = 11;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 1;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_SELF  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_LEFT  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_RIGHT = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_UP    = SLOT_W'(3);
  localparam logic [SLOT_W-1:0] SLOT_DOWN  = SLOT_W'(4);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic [IDX_W-1:0] REG_COLS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_ROWS = IDX_W'(1);

  localparam logic [COL_W-1:0] COLS_RESET = 7'd64;
  localparam logic [ROW_W-1:0] ROWS_RESET = 6'd16;

  localparam logic [CH_W-1:0] ALPHA_CORNER   = 8'd0;
  localparam logic [CH_W-1:0] ALPHA_BORDER   = 8'd128;
  localparam logic [CH_W-1:0] ALPHA_INTERIOR = 8'd255;
  localparam logic [CH_W-1:0] CORNER_RED     = 8'd255;

  localparam logic [11:0] RECIP5      = 12'd3277;
  localparam int          DIV5_SHIFT  = 14;
  localparam int          PROD_W      = 23;

  typedef struct packed {
    logic              latch;
    logic              clr;
    logic              we;
    logic              rd_en;
    logic [SLOT_W-1:0] slot;
    logic              acc_en;
    logic              load_out;
  } cnb_cmd_t;

  typedef struct packed {
    logic                 is_write;
    logic                 wr_ok;
    logic                 rd_ok;
    logic                 corner;
    logic [NUM_SLOTS-1:0] slot_used;
  } cnb_sts_t;

endpackage

/* rtl/core/cnb_ram.sv */
module cnb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cnb_dp.sv */
module cnb_dp #(
  parameter int MAX_COLS = cnb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = cnb_pkg::DEF_MAX_ROWS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [cnb_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [cnb_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       action_i,
  input  logic [cnb_pkg::COL_W-1:0]  col_i,
  input  logic [cnb_pkg::ROW_W-1:0]  row_i,
  input  logic [cnb_pkg::PIX_W-1:0]  pix_i,
  input  cnb_pkg::cnb_cmd_t          cmd_i,
  output cnb_pkg::cnb_sts_t          sts_o,
  output logic [4*cnb_pkg::CH_W-1:0] out_data_o
);

  import cnb_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int ECW   = $clog2(MAX_COLS + 1);
  localparam int ERW   = $clog2(MAX_ROWS + 1);

  logic [COL_W-1:0]  cols_q;
  logic [ROW_W-1:0]  rows_q;
  logic              act_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [PIX_W-1:0]  pix_q;
  logic [SUM_W-1:0]  acc_r_q, acc_g_q, acc_b_q;
  logic [4*CH_W-1:0] out_q;

  logic [ECW-1:0]    cols_eff;
  logic [ERW-1:0]    rows_eff;
  logic [XW-1:0]     xs, x_left, x_right;
  logic [YW-1:0]     ys;
  logic              border;
  logic [AW-1:0]     slot_addr [NUM_SLOTS];
  logic [AW-1:0]     waddr;
  logic [PIX_W-1:0]  rdata;
  logic              five;
  logic [CH_W-1:0]   mean_r, mean_g, mean_b;
  logic [4*CH_W-1:0] out_d;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
    return AW'(x) * AW'(MAX_ROWS) + AW'(y);
  endfunction

  function automatic logic [CH_W-1:0] mean_of(input logic [SUM_W-1:0] sum, input logic n5);
    logic [SUM_W-1:0]  rsum;
    logic [PROD_W-1:0] prod;
    rsum = sum + SUM_W'(2);
    prod = PROD_W'(rsum) * PROD_W'(RECIP5);
    if (n5) begin
      return CH_W'(prod >> DIV5_SHIFT);
    end
    return CH_W'(rsum >> 2);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLS: cols_q <= cfg_data_i;
        REG_ROWS: rows_q <= ROW_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= action_i;
      col_q <= col_i;
      row_q <= row_i;
      pix_q <= pix_i;
    end
    if (cmd_i.clr) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_r_q <= acc_r_q + SUM_W'(rdata[23:16]);
      acc_g_q <= acc_g_q + SUM_W'(rdata[15:8]);
      acc_b_q <= acc_b_q + SUM_W'(rdata[7:0]);
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    if (cols_q < COL_W'(2)) begin
      cols_eff = ECW'(2);
    end else if (32'(cols_q) > 32'(MAX_COLS)) begin
      cols_eff = ECW'(MAX_COLS);
    end else begin
      cols_eff = ECW'(cols_q);
    end
    if (rows_q < ROW_W'(2)) begin
      rows_eff = ERW'(2);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = ERW'(MAX_ROWS);
    end else begin
      rows_eff = ERW'(rows_q);
    end
  end

  always_comb begin
    border  = (col_q == '0) || (row_q == '0);
    xs      = (col_q == '0) ? '0 : XW'(col_q - COL_W'(1));
    ys      = (row_q == '0) ? '0 : YW'(row_q - ROW_W'(1));
    x_left  = (xs == '0) ? XW'(cols_eff - ECW'(1)) : xs - XW'(1);
    x_right = (32'(xs) + 32'd1 >= 32'(cols_eff)) ? '0 : xs + XW'(1);

    slot_addr[SLOT_SELF]  = addr_of(xs, ys);
    slot_addr[SLOT_LEFT]  = addr_of(x_left, ys);
    slot_addr[SLOT_RIGHT] = addr_of(x_right, ys);
    slot_addr[SLOT_UP]    = addr_of(xs, ys - YW'(1));
    slot_addr[SLOT_DOWN]  = addr_of(xs, ys + YW'(1));
    waddr = addr_of(XW'(col_q), YW'(row_q));

    sts_o.is_write = (act_q == ACT_WRITE);
    sts_o.wr_ok    = (32'(col_q) < 32'(cols_eff)) && (32'(row_q) < 32'(rows_eff));
    sts_o.rd_ok    = (32'(col_q) <= 32'(cols_eff)) && (32'(row_q) <= 32'(rows_eff));
    sts_o.corner   = (col_q == '0) && (row_q == '0);
    sts_o.slot_used[SLOT_SELF]  = 1'b1;
    sts_o.slot_used[SLOT_LEFT]  = !border;
    sts_o.slot_used[SLOT_RIGHT] = !border;
    sts_o.slot_used[SLOT_UP]    = !border && (ys != '0);
    sts_o.slot_used[SLOT_DOWN]  = !border && (32'(ys) + 32'd1 < 32'(rows_eff));
  end

  cnb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.we),
    .waddr_i (waddr),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (slot_addr[cmd_i.slot]),
    .rdata_o (rdata)
  );

  always_comb begin
    five   = sts_o.slot_used[SLOT_UP] && sts_o.slot_used[SLOT_DOWN];
    mean_r = mean_of(acc_r_q, five);
    mean_g = mean_of(acc_g_q, five);
    mean_b = mean_of(acc_b_q, five);
    if (sts_o.corner) begin
      out_d = {ALPHA_CORNER, CH_W'(0), CH_W'(0), CORNER_RED};
    end else if (border) begin
      out_d = {ALPHA_BORDER, CH_W'(acc_b_q), CH_W'(acc_g_q), CH_W'(acc_r_q)};
    end else begin
      out_d = {ALPHA_INTERIOR, mean_b, mean_g, mean_r};
    end
  end

  assign out_data_o = out_q;

endmodule

/* rtl/core/cnb_ctrl.sv */
module cnb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  cnb_pkg::cnb_sts_t sts_i,
  output cnb_pkg::cnb_cmd_t cmd_o
);

  import cnb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_FETCH,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] slot_q;
  logic              pend_q;
  logic              m_valid_q;

  always_comb begin
    cmd_o.latch    = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.clr      = (state_q == ST_CLASSIFY);
    cmd_o.we       = (state_q == ST_CLASSIFY) && sts_i.is_write && sts_i.wr_ok;
    cmd_o.rd_en    = (state_q == ST_FETCH) && sts_i.slot_used[slot_q];
    cmd_o.slot     = slot_q;
    cmd_o.acc_en   = pend_q;
    cmd_o.load_out = (state_q == ST_EMIT) && (!m_valid_q || m_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= SLOT_SELF;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      pend_q <= cmd_o.rd_en;
      if (cmd_o.load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.latch) begin
            state_q <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          slot_q <= SLOT_SELF;
          if (sts_i.is_write || !sts_i.rd_ok) begin
            state_q <= ST_IDLE;
          end else if (sts_i.corner) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          if (slot_q == SLOT_DOWN) begin
            slot_q  <= SLOT_SELF;
            state_q <= ST_DRAIN;
          end else begin
            slot_q <= slot_q + SLOT_W'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (cmd_o.load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = m_valid_q;

  a_classify_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.latch |=> cmd_o.clr)
    else $error("accepted beat not classified next cycle");

  a_acc_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_en |-> $past(cmd_o.rd_en))
    else $error("accumulate without a read issued the cycle before");

  a_no_read_in_flight_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !pend_q)
    else $error("store read still in flight while accepting");

  a_valid_rises_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

endmodule

/* rtl/core/cross_neighbor_color_blend.sv */
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: action; tdata: col,row,red,green,blue
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: red,green,blue,alpha
// cfg       in         cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
// One beat in flight at a time: a write or a dropped beat passes classify and returns to idle;
// a corner read passes classify, emit, idle; an interior or border read passes classify, five
// store-read slots on the single read port, drain, emit, idle, and its result is loaded in emit.
// Reset clears control and loads cols_in_use = 64, rows_in_use = 16; the pixel
// store is not cleared. The output register holds one result: a stalled m_axis
// stops the block in emit, and s_axis_tready stays low until that result is loaded.
module cross_neighbor_color_blend #(
  parameter int MAX_COLS = cnb_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = cnb_pkg::DEF_MAX_ROWS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [39:0]               s_axis_tdata,  // col, row, red, green, blue, pad
  input  logic                      s_axis_tuser,  // action
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [31:0]               m_axis_tdata,  // red, green, blue, alpha
  input  logic                      cfg_we_i,
  input  logic [cnb_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [cnb_pkg::CFG_W-1:0] cfg_data_i
);

  cnb_pkg::cnb_cmd_t cmd;
  cnb_pkg::cnb_sts_t sts;

  cnb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cnb_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .action_i   (s_axis_tuser),
    .col_i      (s_axis_tdata[6:0]),
    .row_i      (s_axis_tdata[12:7]),
    .pix_i      ({s_axis_tdata[20:13], s_axis_tdata[28:21], s_axis_tdata[36:29]}),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata)
  );

endmodule
